[sv/spi_mwt_pkg.sv]
// shared types and constants for the spi master word transfer block
package spi_mwt_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_DIVIDER_SELECT = 2'd0;
  localparam logic [1:0] CFG_SPI_MODE       = 2'd1;
  localparam logic [1:0] CFG_LSB_FIRST      = 2'd2;

  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 3;

  // largest divider code that is honored (divide by 128)
  localparam logic [2:0] DIV_SEL_MAX   = 3'd6;
  localparam logic [2:0] DIV_SEL_RESET = 3'd6;

  typedef struct packed {
    logic        start_req;
    logic [2:0]  byte_count;
    logic [31:0] tx_word;
    logic        miso;
  } spi_mwt_in_t;

  typedef struct packed {
    logic        sclk;
    logic        mosi;
    logic        busy_res;
    logic        done_res;
    logic [31:0] rx_word;
  } spi_mwt_out_t;

endpackage

[sv/spi_master_word_transfer.sv]
// spi master shift engine: one transaction per system tick, word of 1 to MAX_BYTES bytes
//
// usage:
//   - input channel (in_valid/in_ready/in_data): one transaction is one system
//     tick carrying start_req, byte_count, tx_word and the sampled miso level
//   - result channel (out_valid/out_ready/out_data): exactly one result per
//     input transaction with sclk, mosi, busy, a one-tick done pulse and rx_word
//   - config port (cfg_we/cfg_addr/cfg_wdata): divider, spi mode, bit order;
//     latched into the engine when a transfer starts, cpol also sets idle sclk
//   - the result of a transaction is registered, seen in the cycle after acceptance
//   - throughput: one transaction per cycle while results are taken, set by the
//     single state update between the input handshake and the output register
//   - a stalled receiver holds the output register; a new transaction is still
//     taken in the cycle the held result leaves
//   - reset: idle, sclk low, divider 128, mode 0, msb first, output empty
//   - sclk period is 2 << divider ticks; a start while busy is ignored
module spi_master_word_transfer
  import spi_mwt_pkg::*;
#(
  parameter int MAX_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  spi_mwt_in_t         in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output spi_mwt_out_t        out_data,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  localparam int W   = MAX_BYTES * 8;          // shift register width
  localparam int BLW = $clog2(W + 1);          // bits left counter width
  localparam int CW  = $clog2(MAX_BYTES + 1);  // latched byte count width

  // configuration registers
  logic [2:0] cfg_div_r;
  logic [1:0] cfg_mode_r;
  logic       cfg_lsb_r;

  // engine state
  logic [6:0]     tick_r, tick_nxt;
  logic [BLW-1:0] bits_left_r, bits_left_nxt;
  logic [W-1:0]   tx_r, tx_nxt;
  logic [W-1:0]   rx_r, rx_nxt;
  logic           sclk_r, sclk_nxt;
  logic           active_r, active_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           lat_lsb_r, lat_lsb_nxt;
  logic [1:0]     lat_mode_r, lat_mode_nxt;
  logic [2:0]     lat_div_r, lat_div_nxt;

  // output register
  logic         out_valid_r, out_valid_nxt;
  spi_mwt_out_t out_data_r, out_data_nxt;

  logic accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_div_r  <= DIV_SEL_RESET;
      cfg_mode_r <= '0;
      cfg_lsb_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DIVIDER_SELECT: cfg_div_r  <= cfg_wdata[2:0];
        CFG_SPI_MODE:       cfg_mode_r <= cfg_wdata[1:0];
        CFG_LSB_FIRST:      cfg_lsb_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // next state and result for one tick
  always_comb begin
    logic [6:0]    tick_inc;
    logic [6:0]    half;
    logic [W-1:0]  rx_smp;
    logic [W-1:0]  rx_fin;
    logic [W-1:0]  rx_recv;
    logic [W-1:0]  word_ext;
    logic [W-1:0]  word_msk;
    logic [W-1:0]  tx_load;
    logic [63:0]   word64;
    logic [63:0]   recv64;
    logic [CW-1:0] cnt_sat;
    logic [BLW-1:0] bl_dec;
    logic          done;
    logic [31:0]   rxw;

    tick_nxt      = tick_r;
    bits_left_nxt = bits_left_r;
    tx_nxt        = tx_r;
    rx_nxt        = rx_r;
    sclk_nxt      = sclk_r;
    active_nxt    = active_r;
    count_nxt     = count_r;
    lat_lsb_nxt   = lat_lsb_r;
    lat_mode_nxt  = lat_mode_r;
    lat_div_nxt   = lat_div_r;
    done          = 1'b0;
    rxw           = '0;

    tick_inc = tick_r + 7'd1;
    half     = 7'd1 << lat_div_r;

    // miso sample into the receive register
    rx_smp = lat_lsb_r ? {in_data.miso, rx_r[W-1:1]} : {rx_r[W-2:0], in_data.miso};

    // contents at the last trailing edge: only cpha 1 samples there
    rx_fin = lat_mode_r[0] ? rx_smp : rx_r;

    // received word: lsb first sits at the top, msb first at the bottom
    rx_recv = '0;
    for (int b = 1; b <= MAX_BYTES; b++) begin
      if (count_r == CW'(b)) begin
        if (lat_lsb_r) begin
          rx_recv = rx_fin >> ((MAX_BYTES - b) * 8);
        end else begin
          rx_recv = rx_fin & (W'({W{1'b1}}) >> ((MAX_BYTES - b) * 8));
        end
      end
    end
    recv64 = 64'(rx_recv);

    bl_dec = (bits_left_r != '0) ? bits_left_r - BLW'(1) : bits_left_r;

    // byte count clamp to 1..MAX_BYTES
    if (in_data.byte_count == 3'd0) begin
      cnt_sat = CW'(1);
    end else if ({1'b0, in_data.byte_count} > 4'(MAX_BYTES)) begin
      cnt_sat = CW'(MAX_BYTES);
    end else begin
      cnt_sat = CW'(in_data.byte_count);
    end

    // load value for the transmit register
    word64   = {32'b0, in_data.tx_word};
    word_ext = word64[W-1:0];
    word_msk = '0;
    tx_load  = '0;
    for (int b = 1; b <= MAX_BYTES; b++) begin
      if (cnt_sat == CW'(b)) begin
        word_msk = word_ext & (W'({W{1'b1}}) >> ((MAX_BYTES - b) * 8));
        tx_load  = cfg_lsb_r ? word_msk : (word_msk << ((MAX_BYTES - b) * 8));
      end
    end

    if (accept) begin
      if (active_r) begin
        if (tick_inc >= half) begin
          tick_nxt = '0;
          sclk_nxt = ~sclk_r;
          if (sclk_r == lat_mode_r[1]) begin
            // leading edge
            if (!lat_mode_r[0]) begin
              rx_nxt = rx_smp;
            end
          end else begin
            // trailing edge
            if (lat_mode_r[0]) begin
              rx_nxt = rx_smp;
            end
            tx_nxt        = lat_lsb_r ? (tx_r >> 1) : (tx_r << 1);
            bits_left_nxt = bl_dec;
            if (bl_dec == '0) begin
              active_nxt = 1'b0;
              done       = 1'b1;
              rxw        = recv64[31:0];
            end
          end
        end else begin
          tick_nxt = tick_inc;
        end
      end else if (in_data.start_req) begin
        count_nxt     = cnt_sat;
        lat_lsb_nxt   = cfg_lsb_r;
        lat_mode_nxt  = cfg_mode_r;
        lat_div_nxt   = (cfg_div_r > DIV_SEL_MAX) ? DIV_SEL_MAX : cfg_div_r;
        tx_nxt        = tx_load;
        rx_nxt        = '0;
        bits_left_nxt = BLW'({cnt_sat, 3'b000});
        tick_nxt      = '0;
        sclk_nxt      = cfg_mode_r[1];
        active_nxt    = 1'b1;
      end

      // idle clock follows the live polarity setting
      if (!active_nxt) begin
        sclk_nxt = cfg_mode_r[1];
        tick_nxt = '0;
      end
    end

    out_data_nxt.sclk     = sclk_nxt;
    out_data_nxt.mosi     = active_nxt ? (lat_lsb_nxt ? tx_nxt[0] : tx_nxt[W-1]) : 1'b0;
    out_data_nxt.busy_res = active_nxt;
    out_data_nxt.done_res = done;
    out_data_nxt.rx_word  = rxw;

    // output register holds until taken
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      bits_left_r <= '0;
      tx_r        <= '0;
      rx_r        <= '0;
      sclk_r      <= 1'b0;
      active_r    <= 1'b0;
      count_r     <= CW'(1);
      lat_lsb_r   <= 1'b0;
      lat_mode_r  <= '0;
      lat_div_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tick_r      <= tick_nxt;
      bits_left_r <= bits_left_nxt;
      tx_r        <= tx_nxt;
      rx_r        <= rx_nxt;
      sclk_r      <= sclk_nxt;
      active_r    <= active_nxt;
      count_r     <= count_nxt;
      lat_lsb_r   <= lat_lsb_nxt;
      lat_mode_r  <= lat_mode_nxt;
      lat_div_r   <= lat_div_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded with each transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

[dv/tb_spi_master_word_transfer.sv]
// testbench for spi_master_word_transfer: random ticks checked against a tick-level predictor
`timescale 1ns / 1ps

module tb_spi_master_word_transfer;
  import spi_mwt_pkg::*;

  localparam int MAX_BYTES    = 4;
  localparam int LONG_HOLD    = 60;      // receiver hold-off that backs up the input
  localparam int LIMIT_CYCLES = 500000;  // generous cap on the whole run

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  spi_mwt_in_t         in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  spi_mwt_out_t        out_data;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  spi_master_word_transfer #(
    .MAX_BYTES(MAX_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ticks waiting to be driven, and pin results waiting to be seen
  spi_mwt_in_t  tick_queue[$];
  spi_mwt_out_t pin_expect[$];

  int n_err      = 0;
  int n_ticks_in = 0;
  int n_ticks_out = 0;
  int n_words    = 0;
  int n_settings = 0;
  int n_cycles   = 0;
  bit calm       = 1'b0;  // no idling on either side once set
  bit held_long  = 1'b0;

  // register copies as the block sees them
  logic [2:0] reg_div  = DIV_SEL_RESET;
  logic [1:0] reg_mode = 2'd0;
  logic       reg_lsb  = 1'b0;

  // shift engine state, latched settings of the running transfer
  int unsigned eng_tick   = 0;
  int unsigned eng_bits   = 0;
  int unsigned eng_nbits  = 8;
  logic [31:0] eng_tx     = '0;
  logic [31:0] eng_rx     = '0;
  logic        eng_sclk   = 1'b0;
  logic        eng_active = 1'b0;
  logic        eng_lsb    = 1'b0;
  logic [1:0]  eng_mode   = 2'd0;
  logic [2:0]  eng_div    = 3'd0;

  // advance the engine by one system tick and return the pins it shows
  function automatic spi_mwt_out_t spi_engine_tick(input spi_mwt_in_t it);
    spi_mwt_out_t r;
    logic         leading;
    logic [63:0]  wmask;
    int unsigned  nbytes;
    r = '0;
    if (eng_active) begin
      eng_tick++;
      if (eng_tick >= (32'd1 << eng_div)) begin
        // leading edge leaves the idle level, trailing edge returns to it
        leading  = (eng_sclk == eng_mode[1]);
        eng_tick = 0;
        eng_sclk = ~eng_sclk;
        // cpha 0 samples on the leading edge, cpha 1 on the trailing one
        if (leading ^ eng_mode[0])
          eng_rx = eng_lsb ? {it.miso, eng_rx[31:1]} : {eng_rx[30:0], it.miso};
        if (!leading) begin
          eng_tx = eng_lsb ? (eng_tx >> 1) : (eng_tx << 1);
          if (eng_bits > 0) eng_bits--;
          if (eng_bits == 0) begin
            eng_active = 1'b0;
            wmask      = (64'd1 << eng_nbits) - 64'd1;
            r.done_res = 1'b1;
            r.rx_word  = eng_lsb ? (eng_rx >> (32 - eng_nbits)) : (eng_rx & wmask[31:0]);
          end
        end
      end
    end else if (it.start_req) begin
      // byte count zero acts as one, above the maximum it saturates
      nbytes = 32'(it.byte_count);
      if (nbytes == 0) nbytes = 1;
      if (nbytes > MAX_BYTES) nbytes = MAX_BYTES;
      eng_nbits  = nbytes * 8;
      eng_lsb    = reg_lsb;
      eng_mode   = reg_mode;
      eng_div    = (reg_div > DIV_SEL_MAX) ? DIV_SEL_MAX : reg_div;
      wmask      = (64'd1 << eng_nbits) - 64'd1;
      eng_tx     = eng_lsb ? (it.tx_word & wmask[31:0])
                           : ((it.tx_word & wmask[31:0]) << (32 - eng_nbits));
      eng_rx     = '0;
      eng_bits   = eng_nbits;
      eng_tick   = 0;
      eng_sclk   = eng_mode[1];
      eng_active = 1'b1;
    end
    // idle sclk follows the current polarity setting
    if (!eng_active) begin
      eng_sclk = reg_mode[1];
      eng_tick = 0;
    end
    r.sclk     = eng_sclk;
    r.mosi     = eng_active ? (eng_lsb ? eng_tx[0] : eng_tx[31]) : 1'b0;
    r.busy_res = eng_active;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
      n_err++;
    end
  endtask

  task automatic push_tick(input logic go, input logic [2:0] nb, input logic [31:0] w,
                           input logic m);
    spi_mwt_in_t it;
    it.start_req  = go;
    it.byte_count = nb;
    it.tx_word    = w;
    it.miso       = m;
    tick_queue.push_back(it);
  endtask

  // register write; only issued with nothing in flight, so the copy can follow at once
  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_DIVIDER_SELECT: reg_div = val;
      CFG_SPI_MODE:       reg_mode = val[1:0];
      CFG_LSB_FIRST:      reg_lsb = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input logic [2:0] div, input logic [1:0] mode, input logic lsb);
    write_reg(CFG_DIVIDER_SELECT, div);
    write_reg(CFG_SPI_MODE, {1'b0, mode});
    write_reg(CFG_LSB_FIRST, {2'b00, lsb});
    n_settings++;
  endtask

  // sender pause: wait for every result, and keep ticking until the transfer ends
  task automatic settle();
    while (1) begin
      while (tick_queue.size() != 0 || in_valid || pin_expect.size() != 0) @(posedge clk);
      if (!eng_active) return;
      repeat (32) push_tick(1'b0, 3'd1, '0, 1'($urandom_range(0, 1)));
    end
  endtask

  // one random phase; slow phases use one-byte words so the long dividers stay short
  task automatic run_phase(input logic [2:0] div, input logic [1:0] mode, input logic lsb,
                           input int n, input bit slow);
    apply_setting(div, mode, lsb);
    for (int i = 0; i < n; i++) begin
      push_tick((slow && i == 0) || $urandom_range(0, 3) == 0,
                slow ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7)),
                $urandom, 1'($urandom_range(0, 1)));
    end
    settle();
  endtask

  // driver: pops ticks, holds valid until taken, predicts each accepted tick
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        pin_expect.push_back(spi_engine_tick(in_data));
        n_ticks_in++;
      end
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (tick_queue.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
        // idle burst of random length
        gap_left <= int'($urandom_range(0, 3));
        in_valid <= 1'b0;
      end else if (tick_queue.size() != 0) begin
        in_data  <= tick_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each accepted result and drives out_ready with stalls
  int hold_left = 0;
  always @(posedge clk) begin : mon
    spi_mwt_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_ticks_out++;
        if (pin_expect.size() == 0) begin
          $error("result with no transaction pending: 0x%0h", out_data);
          n_err++;
        end else begin
          want = pin_expect.pop_front();
          check_field("sclk", 32'(want.sclk), 32'(out_data.sclk));
          check_field("mosi", 32'(want.mosi), 32'(out_data.mosi));
          check_field("busy_res", 32'(want.busy_res), 32'(out_data.busy_res));
          check_field("done_res", 32'(want.done_res), 32'(out_data.done_res));
          check_field("rx_word", want.rx_word, out_data.rx_word);
          if (want.done_res) n_words++;
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!held_long && n_ticks_out > 100 && tick_queue.size() > 40) begin
        // long hold-off while the sender keeps offering, fills the block
        held_long = 1'b1;
        hold_left <= LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold_left <= int'($urandom_range(0, 3));
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle pins under the reset setting (cpol 0, divide by 128)
    repeat (3) push_tick(1'b0, 3'd0, 32'hFFFF_FFFF, 1'b1);
    settle();

    // fastest divider, mode 3, lsb first
    apply_setting(3'd0, 2'd3, 1'b1);
    push_tick(1'b0, 3'd4, 32'hFFFF_FFFF, 1'b1);          // idle sclk high
    push_tick(1'b1, 3'd0, 32'hFFFF_FFFF, 1'b1);          // byte count zero acts as one
    for (int i = 0; i < 16; i++)
      push_tick(1'b1, 3'd4, 32'h0, 1'(i % 2));            // starts while busy are ignored
    push_tick(1'b1, 3'd7, 32'h8000_0001, 1'b1);          // count above max saturates
    push_tick(1'b0, 3'd0, 32'h0, 1'b0);
    settle();

    // random phases over every mode and bit order, fast dividers
    for (int k = 0; k < 8; k++)
      run_phase(3'($urandom_range(0, 2)), 2'(k % 4), 1'(k / 4), 80, 1'b0);

    // slow dividers: divide by 16, and code seven which acts as six
    for (int d = 3; d < 8; d += 4)
      run_phase(3'(d), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 16, 1'b1);

    // last part runs back to back
    calm = 1'b1;
    run_phase(3'd0, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 150, 1'b0);

    repeat (8) @(posedge clk);
    if (pin_expect.size() != 0) begin
      $error("%0d expected results never arrived", pin_expect.size());
      n_err++;
    end

    $display("covered %0d ticks in, %0d results checked, %0d completed words",
             n_ticks_in, n_ticks_out, n_words);
    $display("over %0d register settings: dividers 0 to 3 and 7, all spi modes, both orders",
             n_settings);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
